// ===== rtl/core/sacr_pkg.sv =====
// Shared constants, types and helpers of the cache tag and replacement controller.
// No dependencies; imported by sacr_scan and set_assoc_cache_replacement.
`default_nettype none
package sacr_pkg;

  localparam int unsigned SETS        = 64;
  localparam int unsigned WAYS        = 8;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned ADDR_W      = 32;

  localparam int unsigned OFF_W   = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_W   = $clog2(SETS);
  localparam int unsigned TAG_W   = ADDR_W - SET_W - OFF_W;
  localparam int unsigned WAY_W   = $clog2(WAYS);
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned USE_W   = 16;
  localparam int unsigned CNT_W   = $clog2(WAYS + 1);
  localparam int unsigned OUT_W   = 40;

  localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};

  typedef enum logic [1:0] {
    POL_LRU  = 2'd0,
    POL_FIFO = 2'd1,
    POL_LFU  = 2'd2,
    POL_PLRU = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_UPD
  } state_e;

  // metadata of one set, all ways side by side
  typedef struct packed {
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0]              dirty;
    logic [WAYS-1:0]              recent;
    logic [WAYS-1:0][TAG_W-1:0]   tag;
    logic [WAYS-1:0][STAMP_W-1:0] stamp;
    logic [WAYS-1:0][USE_W-1:0]   use_cnt;
    logic [CNT_W-1:0]             unmarked;
    logic                         full;
    logic [WAY_W-1:0]             fifo_next;
  } row_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim;
  } scan_t;

  function automatic row_t mark_way(row_t r, logic [WAY_W-1:0] w);
    row_t n;
    n = r;
    if (!n.recent[w] && n.unmarked != '0) n.unmarked = n.unmarked - CNT_W'(1);
    if (n.unmarked == '0) begin
      n.recent   = '0;
      n.unmarked = CNT_W'(WAYS - 1);
    end
    n.recent[w] = 1'b1;
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sacr_scan.sv =====
// Way scan unit: one way per cycle while step_i is high, tag match and shared stamp compare for victim pick.
// Depends on sacr_pkg.
`default_nettype none
module sacr_scan import sacr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [WAY_W-1:0]   idx_i,
  input  wire logic               valid_i,
  input  wire logic               tag_eq_i,
  input  wire logic [STAMP_W-1:0] stamp_i,
  input  wire logic [USE_W-1:0]   use_i,
  input  wire logic               lfu_i,
  output scan_t                   res_o
);

  logic               hit_q, hit_d;
  logic [WAY_W-1:0]   hit_way_q, hit_way_d;
  logic [WAY_W-1:0]   vic_q, vic_d;
  logic [STAMP_W-1:0] vstamp_q, vstamp_d;
  logic [USE_W-1:0]   vuse_q, vuse_d;
  logic               first, lt, eq, take;

  assign first = (idx_i == '0);
  assign lt    = stamp_i < vstamp_q;
  assign eq    = stamp_i == vstamp_q;

  always_comb begin
    if (lfu_i) take = first || (use_i < vuse_q) || ((use_i == vuse_q) && lt);
    else       take = first || lt || eq;
    hit_d     = first ? 1'b0 : hit_q;
    hit_way_d = hit_way_q;
    if (!hit_d && valid_i && tag_eq_i) begin
      hit_d     = 1'b1;
      hit_way_d = idx_i;
    end
    vic_d    = take ? idx_i   : vic_q;
    vstamp_d = take ? stamp_i : vstamp_q;
    vuse_d   = take ? use_i   : vuse_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (step_i) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hit_way_q <= hit_way_d;
      vic_q     <= vic_d;
      vstamp_q  <= vstamp_d;
      vuse_q    <= vuse_d;
    end
  end

  assign res_o = '{hit: hit_q, hit_way: hit_way_q, victim: vic_q};

endmodule
`default_nettype wire

// ===== rtl/core/set_assoc_cache_replacement.sv =====
// Top level of the set-associative cache tag and replacement controller.
// Depends on sacr_pkg and sacr_scan.
//
// Usage:
// - s_axis: one access item; tdata = byte address, tuser = kind (0 read, 1 write).
// - m_axis: one result item per access (fields in tdata, see port comment).
// - policy_we_i/policy_i write the replacement policy; the user must do so only
//   while the block is idle, which the block itself does not enforce.
// - Each access: one set-row memory read, then the scan unit steps through the
//   8 ways one per cycle, then the update step writes the row back and registers
//   the result. The block takes no new item before it is through with the last;
//   the next item is taken once the block is back in idle after the update.
// - The result sits in an output register; the block accepts the next item
//   while it waits. A stalled receiver holds the next update cycle until
//   the register frees up.
// - After reset a clearing pass writes every set row, during which no item is
//   taken. Policy resets to LRU.
`default_nettype none
module set_assoc_cache_replacement import sacr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,   // [31:0] addr
  input  wire logic              s_axis_tuser,   // [0] func
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [0] hit, [3:1] way, [4] writeback_valid, [36:5] writeback_addr, [37] fill_valid
  output      logic [OUT_W-1:0]  m_axis_tdata,
  input  wire logic              policy_we_i,
  input  wire logic [1:0]        policy_i
);

  state_e             state_q, state_d;
  logic [SET_W-1:0]   clr_q, clr_d;
  logic [WAY_W-1:0]   way_q, way_d;
  logic [ADDR_W-1:0]  addr_q;
  logic               wr_q;
  logic [31:0]        count_q;
  policy_e            policy_q;
  logic               mv_q, mv_d;
  logic [OUT_W-1:0]   md_q;

  row_t               mem [SETS];
  row_t               row_q, nr, clr_row;
  logic               mem_we, mem_re;
  logic [SET_W-1:0]   mem_waddr;
  row_t               mem_wdata;

  logic               accept, upd_go, step;
  logic [SET_W-1:0]   set_idx;
  logic [TAG_W-1:0]   tag_in;
  scan_t              scan;

  logic               hit, wbv, fill, has_inv, has_unmk;
  logic [WAY_W-1:0]   way_o, inv_way, unmk_way, v;
  logic [ADDR_W-1:0]  wba;

  assign set_idx = addr_q[OFF_W +: SET_W];
  assign tag_in  = addr_q[ADDR_W-1 -: TAG_W];
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign upd_go  = (state_q == ST_UPD) && (!mv_q || m_axis_tready);
  assign step    = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_RD;
      ST_RD:    state_d = ST_SCAN;
      ST_SCAN:  if (way_q == WAY_W'(WAYS - 1)) state_d = ST_UPD;
      ST_UPD:   if (upd_go) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    mem_re        = (state_q == ST_RD);
    clr_d         = (state_q == ST_CLEAR) ? clr_q + SET_W'(1) : clr_q;
    way_d         = step ? way_q + WAY_W'(1) : '0;
    mv_d          = upd_go ? 1'b1 : (m_axis_tready ? 1'b0 : mv_q);
    mem_we        = (state_q == ST_CLEAR) || upd_go;
    mem_waddr     = (state_q == ST_CLEAR) ? clr_q : set_idx;
    mem_wdata     = (state_q == ST_CLEAR) ? clr_row : nr;
  end

  always_comb begin
    clr_row          = '0;
    clr_row.unmarked = CNT_W'(WAYS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      way_q    <= '0;
      count_q  <= '0;
      policy_q <= POL_LRU;
      mv_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      way_q   <= way_d;
      mv_q    <= mv_d;
      if (accept) count_q <= count_q + 32'd1;
      if (policy_we_i) policy_q <= policy_e'(policy_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= s_axis_tdata;
      wr_q   <= s_axis_tuser;
    end
    if (upd_go) md_q <= {2'b00, fill, wba, wbv, way_o, hit};
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) row_q <= mem[set_idx];
  end

  sacr_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .idx_i    (way_q),
    .valid_i  (row_q.valid[way_q]),
    .tag_eq_i (row_q.tag[way_q] == tag_in),
    .stamp_i  (row_q.stamp[way_q]),
    .use_i    (row_q.use_cnt[way_q]),
    .lfu_i    (policy_q == POL_LFU),
    .res_o    (scan)
  );

  always_comb begin
    has_inv  = 1'b0;
    inv_way  = '0;
    has_unmk = 1'b0;
    unmk_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!row_q.valid[i]) begin
        has_inv = 1'b1;
        inv_way = WAY_W'(i);
      end
      if (!row_q.recent[i]) begin
        has_unmk = 1'b1;
        unmk_way = WAY_W'(i);
      end
    end
  end

  always_comb begin
    nr    = row_q;
    hit   = 1'b0;
    wbv   = 1'b0;
    wba   = '0;
    fill  = 1'b0;
    way_o = '0;
    v     = '0;
    if (scan.hit) begin
      v     = scan.hit_way;
      hit   = 1'b1;
      way_o = v;
      nr.stamp[v] = count_q;
      if (nr.use_cnt[v] != USE_MAX) nr.use_cnt[v] = nr.use_cnt[v] + USE_W'(1);
      nr = mark_way(nr, v);
      if (wr_q) nr.dirty[v] = 1'b1;
    end else if (!row_q.full && has_inv) begin
      v = inv_way;
      case (policy_q)
        POL_LRU: nr.stamp[v] = count_q;
        POL_LFU: begin
          nr.use_cnt[v] = USE_W'(1);
          nr.stamp[v]   = count_q;
        end
        POL_PLRU: nr = mark_way(nr, v);
        default: ;
      endcase
      nr.valid[v] = 1'b1;
      nr.tag[v]   = tag_in;
      nr.dirty[v] = wr_q;
      way_o       = v;
      fill        = !wr_q;
    end else begin
      nr.full = 1'b1;
      case (policy_q)
        POL_LRU: v = scan.victim;
        POL_FIFO: begin
          v = row_q.fifo_next;
          nr.fifo_next = (v == WAY_W'(WAYS - 1)) ? '0 : v + WAY_W'(1);
        end
        POL_LFU: begin
          v = scan.victim;
          nr.use_cnt    = '0;
          nr.use_cnt[v] = USE_W'(1);
        end
        POL_PLRU: begin
          v  = has_unmk ? unmk_way : '0;
          nr = mark_way(nr, v);
        end
        default: v = '0;
      endcase
      nr.stamp[v] = count_q;
      if (row_q.dirty[v]) begin
        wbv = 1'b1;
        wba = {row_q.tag[v], set_idx, {OFF_W{1'b0}}};
      end
      nr.valid[v] = 1'b1;
      nr.tag[v]   = tag_in;
      nr.dirty[v] = wr_q;
      way_o       = v;
      fill        = !wr_q;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == ST_IDLE))
    else $error("ready outside idle");

  a_accept_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RD))
    else $error("accept did not start a row read");

  a_upd_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("update did not register a result");

  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_SCAN && way_q == '0))
    else $error("scan did not start at way zero");

endmodule
`default_nettype wire

// ===== tb/tb_set_assoc_cache_replacement.sv =====
// Testbench of the set-associative cache tag and replacement controller.
// Drives access items, predicts hit, way, write-back and fill per policy, checks each result.
// Depends on sacr_pkg and set_assoc_cache_replacement.
`default_nettype none
module tb_set_assoc_cache_replacement;
  import sacr_pkg::*;

  typedef struct packed {
    logic        fill;
    logic [31:0] wb_addr;
    logic        wb;
    logic [2:0]  way;
    logic        hit;
  } result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              policy_we_i = 1'b0;
  logic [1:0]        policy_i = '0;

  set_assoc_cache_replacement u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .policy_we_i, .policy_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [WAYS-1:0]         p_valid [SETS];
  logic [WAYS-1:0]         p_dirty [SETS];
  logic [WAYS-1:0]         p_recent[SETS];
  logic [TAG_W-1:0]        p_tag   [SETS][WAYS];
  logic [31:0]             p_stamp [SETS][WAYS];
  logic [15:0]             p_uses  [SETS][WAYS];
  int unsigned             p_unmarked[SETS];
  logic                    p_full  [SETS];
  int unsigned             p_fifo  [SETS];
  logic [31:0]             p_accesses;
  policy_e                 p_policy;

  result_t     expected_results[$];
  int          mismatches = 0;
  bit          quiet = 1'b1;
  int          stall_pct = 7;
  int          idle_cycles = 0;
  logic [TAG_W-1:0] tag_pool[8];

  task automatic predictor_reset();
    for (int s = 0; s < SETS; s++) begin
      p_valid[s] = '0; p_dirty[s] = '0; p_recent[s] = '0;
      p_unmarked[s] = WAYS; p_full[s] = 1'b0; p_fifo[s] = 0;
      for (int w = 0; w < WAYS; w++) begin
        p_tag[s][w] = '0; p_stamp[s][w] = '0; p_uses[s][w] = '0;
      end
    end
    p_accesses = '0;
    p_policy = POL_LRU;
  endtask

  task automatic mark_recent(int s, int w);
    if (!p_recent[s][w] && p_unmarked[s] > 0) p_unmarked[s]--;
    if (p_unmarked[s] == 0) begin
      p_recent[s] = '0;
      p_unmarked[s] = WAYS - 1;
    end
    p_recent[s][w] = 1'b1;
  endtask

  task automatic predict_access(logic [31:0] addr, logic wr);
    int s, w, v;
    logic [TAG_W-1:0] t;
    result_t r;
    logic [31:0] least;
    s = int'(addr[OFF_W +: SET_W]);
    t = addr[31 -: TAG_W];
    r = '0;
    p_accesses++;
    w = -1;
    for (int i = 0; i < WAYS; i++)
      if (w < 0 && p_valid[s][i] && p_tag[s][i] == t) w = i;
    if (w >= 0) begin
      p_stamp[s][w] = p_accesses;
      if (p_uses[s][w] != 16'hffff) p_uses[s][w]++;
      mark_recent(s, w);
      if (wr) p_dirty[s][w] = 1'b1;
      r.hit = 1'b1; r.way = w[2:0];
      expected_results.push_back(r);
      return;
    end
    r.fill = !wr;
    if (!p_full[s]) begin
      v = -1;
      for (int i = 0; i < WAYS; i++) if (v < 0 && !p_valid[s][i]) v = i;
      if (v >= 0) begin
        case (p_policy)
          POL_LRU:  p_stamp[s][v] = p_accesses;
          POL_LFU:  begin p_uses[s][v] = 16'd1; p_stamp[s][v] = p_accesses; end
          POL_PLRU: mark_recent(s, v);
          default: ;
        endcase
        p_valid[s][v] = 1'b1; p_tag[s][v] = t; p_dirty[s][v] = wr;
        r.way = v[2:0];
        expected_results.push_back(r);
        return;
      end
    end
    p_full[s] = 1'b1;
    v = 0;
    case (p_policy)
      POL_LRU:
        for (int i = 1; i < WAYS; i++) if (!(p_stamp[s][v] < p_stamp[s][i])) v = i;
      POL_FIFO: begin
        v = p_fifo[s] % WAYS;
        p_fifo[s] = (v + 1) % WAYS;
      end
      POL_LFU: begin
        least = 32'h7fffffff;
        for (int i = 0; i < WAYS; i++)
          if (p_uses[s][i] < least) begin v = i; least = 32'(p_uses[s][i]); end
        for (int i = 0; i < WAYS; i++)
          if (p_uses[s][i] == least && p_stamp[s][i] < p_stamp[s][v]) v = i;
        for (int i = 0; i < WAYS; i++) p_uses[s][i] = '0;
        p_uses[s][v] = 16'd1;
      end
      default: begin
        v = -1;
        for (int i = 0; i < WAYS; i++) if (v < 0 && !p_recent[s][i]) v = i;
        if (v < 0) v = 0;
        mark_recent(s, v);
      end
    endcase
    p_stamp[s][v] = p_accesses;
    if (p_dirty[s][v]) begin
      r.wb = 1'b1;
      r.wb_addr = {p_tag[s][v], s[SET_W-1:0], {OFF_W{1'b0}}};
    end
    p_tag[s][v] = t; p_dirty[s][v] = wr;
    r.way = v[2:0];
    expected_results.push_back(r);
  endtask

  task automatic send_access(logic [31:0] addr, logic wr);
    while (!quiet && $urandom_range(99) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= wr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_access(addr, wr);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_policy(policy_e pol);
    drain();
    policy_we_i <= 1'b1;
    policy_i    <= pol;
    @(negedge clk_i);
    policy_we_i <= 1'b0;
    p_policy = pol;
  endtask

  function automatic logic [31:0] make_addr(logic [TAG_W-1:0] t, int s);
    return {t, s[SET_W-1:0], 6'($urandom)};
  endfunction

  // extremes of the address, fills, write hits, dirty eviction
  task automatic test_directed();
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hffff_ffff, 1'b1);
    send_access(32'hffff_ffc0, 1'b0);
    send_access(32'h0000_003f, 1'b1);
    for (int i = 0; i < 9; i++) send_access({20'(i + 1), 6'd5, 6'd0}, 1'b1);
    send_access({20'd1, 6'd5, 6'd0}, 1'b0);
    send_access({20'd9, 6'd5, 6'd7}, 1'b0);
    send_access(32'haaaa_aaaa, 1'b1);
    send_access(32'h5555_5555, 1'b0);
  endtask

  task automatic test_policy(policy_e pol, int count);
    int s;
    set_policy(pol);
    for (int i = 0; i < 8; i++) tag_pool[i] = TAG_W'($urandom);
    for (int i = 0; i < count; i++) begin
      s = $urandom_range(3);
      if ($urandom_range(9) == 0) send_access($urandom, 1'($urandom_range(1)));
      else send_access(make_addr(tag_pool[$urandom_range(7)] ^ TAG_W'($urandom_range(3)),
                                 s), 1'($urandom_range(1)));
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      idle_cycles <= 0;
      got = result_t'(m_axis_tdata[37:0]);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp hit=%b way=%0d wb=%b wba=%h fill=%b,",
                      " got hit=%b way=%0d wb=%b wba=%h fill=%b"},
                     want.hit, want.way, want.wb, want.wb_addr, want.fill,
                     got.hit, got.way, got.wb, got.wb_addr, got.fill);
        end
      end
    end else if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= stall_pct);

  initial begin
    predictor_reset();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    quiet = 1'b0;
    test_policy(POL_FIFO, 100);
    test_policy(POL_LFU, 100);
    test_policy(POL_PLRU, 100);
    test_policy(POL_LRU, 100);
    drain();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/sacr_pkg.sv
rtl/core/sacr_scan.sv
rtl/core/set_assoc_cache_replacement.sv
tb/tb_set_assoc_cache_replacement.sv
